>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define LRUC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define LRUC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LRUC_ASSERT(lbl, clk, rstn, prop, msg)
`define LRUC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hdl/lruc_pkg.sv
package lruc_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int NAME_BYTES  = 20;
  localparam int KEY_W       = 160;
  localparam int CFG_W       = 6;
  localparam int COST_W      = 3;
  localparam int TOTAL_W     = 24;

  localparam logic [COST_W-1:0]  COST_HIT  = 3'd1;
  localparam logic [COST_W-1:0]  COST_MISS = 3'd5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hit_upd;
    logic drop;
    logic insert;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic must_drop;
    logic can_insert;
  } status_t;

  // Clears bytes beyond the name length and folds upper-case ASCII to lower case.
  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic [7:0]       b;
    res = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      b = raw[i*8 +: 8];
      if (i >= NAME_BYTES) begin
        b = 8'h00;
      end
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b | 8'h20;
      end
      res[i*8 +: 8] = b;
    end
    return res;
  endfunction

endpackage

>>> hdl/lruc_ctrl.sv
`include "assert_macros.svh"

module lruc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lruc_pkg::status_t status,
  output lruc_pkg::cmd_t    cmd
);

  lruc_pkg::state_t state_r;
  lruc_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lruc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    out_free  = !out_valid_r || !out_stall;
    unique case (state_r)
      lruc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = lruc_pkg::ST_UPDATE;
        end
      end
      lruc_pkg::ST_UPDATE: begin
        if (status.hit) begin
          if (out_free) begin
            cmd.hit_upd = 1'b1;
            cmd.finish  = 1'b1;
            state_nxt   = lruc_pkg::ST_IDLE;
          end
        end else if (status.must_drop) begin
          // One eviction per cycle until a slot is free below the capacity.
          cmd.drop = 1'b1;
        end else if (out_free) begin
          cmd.insert = status.can_insert;
          cmd.finish = 1'b1;
          state_nxt  = lruc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lruc_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  end

  assign in_stall  = (state_r != lruc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `LRUC_ASSERT(a_finish_free, clk, rst_n, !cmd.finish || !out_valid_r || !out_stall, "result overwritten while pending")
  `LRUC_ASSERT(a_drop_miss, clk, rst_n, !(cmd.drop && status.hit), "eviction issued on a hit")
  `LRUC_ASSERT_NEXT(a_one_req, clk, rst_n, cmd.accept, !cmd.accept, "request accepted while one is in work")

endmodule

>>> hdl/lruc_datapath.sv
`include "assert_macros.svh"

module lruc_datapath #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lruc_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic [63:0]                     in_key_bytes_low,
  input  logic [63:0]                     in_key_bytes_mid,
  input  logic [31:0]                     in_key_bytes_high,
  input  logic                            in_batch_start,
  input  lruc_pkg::cmd_t                  cmd,
  output lruc_pkg::status_t               status,
  output logic                            out_hit,
  output logic [lruc_pkg::COST_W-1:0]     out_access_cost,
  output logic [lruc_pkg::TOTAL_W-1:0]    out_total_time
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lruc_pkg::CFG_W) ? CNT_W : lruc_pkg::CFG_W;
  localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(ENTRIES);

  logic [lruc_pkg::CFG_W-1:0]   cache_size_r;
  logic [lruc_pkg::KEY_W-1:0]   key_r [ENTRIES];
  logic [IDX_W-1:0]             rank_r [ENTRIES];
  logic [IDX_W-1:0]             rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]           valid_r;
  logic [ENTRIES-1:0]           valid_nxt;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [lruc_pkg::TOTAL_W-1:0] acc_r;
  logic [lruc_pkg::TOTAL_W-1:0] acc_nxt;
  logic [lruc_pkg::KEY_W-1:0]   cur_key_r;
  logic [ENTRIES-1:0]           match_r;
  logic [ENTRIES-1:0]           match_nxt;
  logic                         hit_r;
  logic                         out_hit_r;
  logic [lruc_pkg::COST_W-1:0]  out_cost_r;
  logic [lruc_pkg::TOTAL_W-1:0] out_total_r;

  logic [lruc_pkg::KEY_W-1:0]   in_key_fold;
  logic [CMP_W-1:0]             size_cmp;
  logic [CMP_W-1:0]             cap;
  logic [IDX_W-1:0]             hit_rank;
  logic [IDX_W-1:0]             top_rank;
  logic [ENTRIES-1:0]           free_oh;
  logic [lruc_pkg::COST_W-1:0]  cost;
  logic [lruc_pkg::TOTAL_W:0]   sum;
  logic [lruc_pkg::TOTAL_W-1:0] total_sat;

  assign in_key_fold = lruc_pkg::fold_key({in_key_bytes_high, in_key_bytes_mid,
                                           in_key_bytes_low});

  // Capacity is the configured size limited to the number of slots.
  assign size_cmp = CMP_W'(cache_size_r);
  assign cap      = (size_cmp > ENTRIES_CMP) ? ENTRIES_CMP : size_cmp;

  assign status.hit        = hit_r;
  assign status.must_drop  = (count_r != '0) && (CMP_W'(count_r) >= cap);
  assign status.can_insert = (cap != '0);

  // Lowest free slot as a one-hot vector.
  assign free_oh  = ~valid_r & (valid_r + ENTRIES'(1));
  assign top_rank = IDX_W'(count_r - CNT_W'(1));

  assign cost      = hit_r ? lruc_pkg::COST_HIT : lruc_pkg::COST_MISS;
  assign sum       = {1'b0, acc_r} + (lruc_pkg::TOTAL_W + 1)'(cost);
  assign total_sat = sum[lruc_pkg::TOTAL_W] ? lruc_pkg::TOTAL_MAX
                                            : sum[lruc_pkg::TOTAL_W-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && !in_batch_start && (key_r[i] == in_key_fold);
    end
  end

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (match_r[i] ? rank_r[i] : '0);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    if (cmd.accept && in_batch_start) begin
      valid_nxt = '0;
      count_nxt = '0;
      acc_nxt   = '0;
    end
    if (cmd.hit_upd) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (valid_r[k] && rank_r[k] > hit_rank) begin
          rank_nxt[k] = rank_r[k] - IDX_W'(1);
        end
        if (match_r[k]) begin
          rank_nxt[k] = top_rank;
        end
      end
    end
    if (cmd.drop) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i]) begin
          if (rank_r[i] == '0) begin
            valid_nxt[i] = 1'b0;
          end else begin
            rank_nxt[i] = rank_r[i] - IDX_W'(1);
          end
        end
      end
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = IDX_W'(count_r);
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      acc_nxt = total_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_size_r <= '0;
      valid_r      <= '0;
      count_r      <= '0;
      acc_r        <= '0;
      match_r      <= '0;
      hit_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cache_size_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      if (cmd.accept) begin
        match_r <= match_nxt;
        hit_r   <= |match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    if (cmd.accept) begin
      cur_key_r <= in_key_fold;
    end
    if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          key_r[i] <= cur_key_r;
        end
      end
    end
    if (cmd.finish) begin
      out_hit_r   <= hit_r;
      out_cost_r  <= cost;
      out_total_r <= total_sat;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_access_cost = out_cost_r;
  assign out_total_time  = out_total_r;

  `LRUC_ASSERT(a_count_pop, clk, rst_n, count_r == CNT_W'($countones(valid_r)), "count differs from occupied slots")
  `LRUC_ASSERT(a_match_one, clk, rst_n, $onehot0(match_r), "key stored in more than one slot")
  `LRUC_ASSERT(a_insert_room, clk, rst_n, !cmd.insert || !(&valid_r), "insert with no free slot")

endmodule

>>> hdl/lru_cache_hit_cost_tracker.sv
// Timing: an accepted request has its result registered by the update state on a hit or on a
//   miss that finds room, once the output is free; least-recent evictions come before it.
// Requests are taken one at a time, the tag compare followed by the recency update; a miss on a
//   full cache also evicts, more than once when the size was lowered below the occupancy.
// Reset (synchronous, rst_n low): cache emptied, total and cache_size cleared, no result pending;
//   there is no clearing pass, so requests are taken as soon as reset is released.
//
// The block is a fully associative LRU cache of 160-bit folded name keys. Every slot holds a
// key, a recency rank and an occupied flag. On acceptance the folded key is compared against all
// occupied slots at once and the match vector is registered; a batch start empties the cache and
// the running total in that same cycle, so the compare sees an empty cache. In the update cycle a
// hit moves its slot to the most recent rank; a miss first evicts the rank-zero slot, one per
// cycle, while the occupancy is at or above the capacity, then writes the key into the lowest free
// slot with the newest rank. The capacity is cache_size limited to ENTRIES; with a capacity of
// zero every miss empties the cache and stores nothing. The result is held in an output register,
// so the next request is accepted while a finished result still waits to be taken.
module lru_cache_hit_cost_tracker #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lruc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [63:0]                   in_key_bytes_low,
  input  logic [63:0]                   in_key_bytes_mid,
  input  logic [31:0]                   in_key_bytes_high,
  input  logic                          in_batch_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lruc_pkg::COST_W-1:0]   out_access_cost,
  output logic [lruc_pkg::TOTAL_W-1:0]  out_total_time
);

  lruc_pkg::cmd_t    cmd;
  lruc_pkg::status_t status;

  // Sequencer: acceptance, hit update, evictions, insert and result handoff.
  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Key store, recency ranks, configuration register and cost accounting.
  lruc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_key_bytes_low  (in_key_bytes_low),
    .in_key_bytes_mid  (in_key_bytes_mid),
    .in_key_bytes_high (in_key_bytes_high),
    .in_batch_start    (in_batch_start),
    .cmd               (cmd),
    .status            (status),
    .out_hit           (out_hit),
    .out_access_cost   (out_access_cost),
    .out_total_time    (out_total_time)
  );

endmodule
